// ----- design/mqtt_packet_stream_parser_assert.svh -----
// assertion macros shared by the mqtt packet stream parser rtl
// needs a clk and rst signal in the scope of each use
`ifndef MQTT_PACKET_STREAM_PARSER_ASSERT_SVH
`define MQTT_PACKET_STREAM_PARSER_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define MPSP_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// condition must hold in the cycle after the trigger
`define MPSP_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ----- design/mpsp_pkg.sv -----
// types and codes for the mqtt packet stream parser
// no dependencies
package mpsp_pkg;

  typedef enum logic [3:0] {
    PH_TYPE,
    PH_LEN,
    PH_TLHI,
    PH_TLLO,
    PH_TOPIC,
    PH_PKTID,
    PH_PAYLOAD,
    PH_SKIP,
    PH_HALT
  } phase_t;

  localparam logic [2:0] CLASS_HEADER  = 3'd0;
  localparam logic [2:0] CLASS_TOPIC   = 3'd1;
  localparam logic [2:0] CLASS_PKTID   = 3'd2;
  localparam logic [2:0] CLASS_PAYLOAD = 3'd3;
  localparam logic [2:0] CLASS_IGNORED = 3'd4;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_TOO_LARGE  = 2'd1;
  localparam logic [1:0] ERR_BAD_LENGTH = 2'd2;

  localparam logic [3:0] TYPE_PUBLISH = 4'd3;

  localparam int LEN_W = 28;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 28'h010_0000;

  typedef struct packed {
    phase_t           phase;
    logic [3:0]       ctype;
    logic [1:0]       qos;
    logic [LEN_W-1:0] accum;
    logic [2:0]       count;
    logic [LEN_W-1:0] body_left;
    logic [15:0]      topic_left;
    logic [1:0]       err;
  } parse_state_t;

  typedef struct packed {
    logic [2:0] byte_class;
    logic [7:0] data_byte;
    logic [3:0] packet_type;
    logic [1:0] qos_level;
    logic       packet_end;
    logic [1:0] error_status;
  } result_t;

endpackage

// ----- design/mpsp_byte_if.sv -----
// valid/ready channel carrying one received stream byte
// no dependencies
interface mpsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

// ----- design/mpsp_result_if.sv -----
// valid/ready channel carrying one classified byte
// no dependencies
interface mpsp_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] byte_class;
  logic [7:0] data_byte;
  logic [3:0] packet_type;
  logic [1:0] qos_level;
  logic       packet_end;
  logic [1:0] error_status;

  modport source(output valid, output byte_class, output data_byte, output packet_type,
                 output qos_level, output packet_end, output error_status, input ready);
  modport sink(input valid, input byte_class, input data_byte, input packet_type,
               input qos_level, input packet_end, input error_status, output ready);
endinterface

// ----- design/mpsp_step.sv -----
// per-byte parse step: next parser state and the classification of one byte
// depends on mpsp_pkg
module mpsp_step (
  input  mpsp_pkg::parse_state_t        st,
  input  logic [7:0]                    rx_byte,
  input  logic [mpsp_pkg::LEN_W-1:0]    max_len,
  output mpsp_pkg::parse_state_t        st_next,
  output mpsp_pkg::result_t             res
);

  logic [mpsp_pkg::LEN_W-1:0] len_shifted;
  logic [mpsp_pkg::LEN_W-1:0] accum_new;
  logic [2:0]                 count_new;
  logic                       len_more;
  logic                       len_too_big;
  logic [mpsp_pkg::LEN_W-1:0] body_dec;
  logic                       body_last;
  logic [15:0]                topic_full;
  logic [16:0]                topic_need;
  logic                       topic_misfit;
  logic [15:0]                topic_dec;
  logic                       topic_last;
  logic                       is_publish;
  logic [2:0]                 cls;
  logic                       pkt_end;

  // 7 bits per length byte, low group first
  always_comb begin
    case (st.count[1:0])
      2'd0:    len_shifted = {21'd0, rx_byte[6:0]};
      2'd1:    len_shifted = {14'd0, rx_byte[6:0], 7'd0};
      2'd2:    len_shifted = {7'd0, rx_byte[6:0], 14'd0};
      default: len_shifted = {rx_byte[6:0], 21'd0};
    endcase
  end

  assign accum_new    = st.accum | len_shifted;
  assign count_new    = st.count + 3'd1;
  assign len_more     = rx_byte[7];
  assign len_too_big  = !len_more && (accum_new > max_len);
  assign body_dec     = (st.body_left != '0) ? st.body_left - 28'd1 : st.body_left;
  assign body_last    = (body_dec == '0);
  assign topic_full   = {st.topic_left[15:8], rx_byte};
  assign topic_need   = {1'b0, topic_full} + ((st.qos != 2'd0) ? 17'd2 : 17'd0);
  assign topic_misfit = {11'd0, topic_need} > body_dec;
  assign topic_dec    = (st.topic_left != '0) ? st.topic_left - 16'd1 : st.topic_left;
  assign topic_last   = (topic_dec == '0);
  assign is_publish   = (st.ctype == mpsp_pkg::TYPE_PUBLISH);

  // next state
  always_comb begin
    st_next = st;
    case (st.phase)
      mpsp_pkg::PH_HALT: begin
      end
      mpsp_pkg::PH_TYPE: begin
        st_next.ctype = rx_byte[7:4];
        st_next.qos   = (rx_byte[7:4] == mpsp_pkg::TYPE_PUBLISH) ? rx_byte[2:1] : 2'd0;
        st_next.accum = '0;
        st_next.count = '0;
        st_next.phase = mpsp_pkg::PH_LEN;
      end
      mpsp_pkg::PH_LEN: begin
        st_next.accum = accum_new;
        st_next.count = count_new;
        if (len_more) begin
          if (count_new >= 3'd4) begin
            st_next.err   = mpsp_pkg::ERR_BAD_LENGTH;
            st_next.phase = mpsp_pkg::PH_HALT;
          end
        end else if (len_too_big) begin
          st_next.err   = mpsp_pkg::ERR_TOO_LARGE;
          st_next.phase = mpsp_pkg::PH_HALT;
        end else begin
          st_next.body_left = accum_new;
          if (accum_new == '0) begin
            st_next.phase = mpsp_pkg::PH_TYPE;
          end else if (is_publish) begin
            st_next.phase = (accum_new < 28'd2) ? mpsp_pkg::PH_SKIP : mpsp_pkg::PH_TLHI;
          end else begin
            st_next.phase = mpsp_pkg::PH_SKIP;
          end
        end
      end
      default: begin
        st_next.body_left = body_dec;
        case (st.phase)
          mpsp_pkg::PH_TLHI: begin
            st_next.topic_left = {rx_byte, 8'd0};
            st_next.phase      = mpsp_pkg::PH_TLLO;
          end
          mpsp_pkg::PH_TLLO: begin
            st_next.topic_left = topic_full;
            if (topic_misfit) begin
              st_next.phase = mpsp_pkg::PH_SKIP;
            end else if (topic_full != '0) begin
              st_next.phase = mpsp_pkg::PH_TOPIC;
            end else if (st.qos != 2'd0) begin
              st_next.topic_left = 16'd2;
              st_next.phase      = mpsp_pkg::PH_PKTID;
            end else begin
              st_next.phase = mpsp_pkg::PH_PAYLOAD;
            end
          end
          mpsp_pkg::PH_TOPIC: begin
            st_next.topic_left = topic_dec;
            if (topic_last) begin
              if (st.qos != 2'd0) begin
                st_next.topic_left = 16'd2;
                st_next.phase      = mpsp_pkg::PH_PKTID;
              end else begin
                st_next.phase = mpsp_pkg::PH_PAYLOAD;
              end
            end
          end
          mpsp_pkg::PH_PKTID: begin
            st_next.topic_left = topic_dec;
            if (topic_last) begin
              st_next.phase = mpsp_pkg::PH_PAYLOAD;
            end
          end
          mpsp_pkg::PH_PAYLOAD: begin
          end
          default: begin
            st_next.phase = mpsp_pkg::PH_SKIP;
          end
        endcase
        if (body_last) begin
          st_next.phase = mpsp_pkg::PH_TYPE;
        end
      end
    endcase
  end

  // byte class and end of packet
  always_comb begin
    cls     = mpsp_pkg::CLASS_HEADER;
    pkt_end = 1'b0;
    case (st.phase)
      mpsp_pkg::PH_HALT: begin
        cls = mpsp_pkg::CLASS_IGNORED;
      end
      mpsp_pkg::PH_TYPE: begin
      end
      mpsp_pkg::PH_LEN: begin
        pkt_end = !len_more && !len_too_big && (accum_new == '0);
      end
      mpsp_pkg::PH_TLHI, mpsp_pkg::PH_TLLO: begin
        pkt_end = body_last;
      end
      mpsp_pkg::PH_TOPIC: begin
        cls     = mpsp_pkg::CLASS_TOPIC;
        pkt_end = body_last;
      end
      mpsp_pkg::PH_PKTID: begin
        cls     = mpsp_pkg::CLASS_PKTID;
        pkt_end = body_last;
      end
      mpsp_pkg::PH_PAYLOAD: begin
        cls     = mpsp_pkg::CLASS_PAYLOAD;
        pkt_end = body_last;
      end
      default: begin
        cls     = mpsp_pkg::CLASS_IGNORED;
        pkt_end = body_last;
      end
    endcase
  end

  assign res.byte_class   = cls;
  assign res.data_byte    = rx_byte;
  assign res.packet_type  = st_next.ctype;
  assign res.qos_level    = st_next.qos;
  assign res.packet_end   = pkt_end;
  assign res.error_status = st_next.err;

endmodule

// ----- design/mqtt_packet_stream_parser.sv -----
// top level of the mqtt 3.1.1 server packet stream parser
// depends on mpsp_pkg, mpsp_byte_if, mpsp_result_if, mpsp_step and the assertion header
//
// usage
//   rx: one received broker byte per transaction (valid/ready, rx_byte)
//   parsed: one result transaction per input byte, same order: byte class
//     (header/length, topic, packet id, payload, ignored), the byte itself,
//     packet type, publish qos, last-byte-of-packet flag and error status
//   cfg_wr_en/cfg_wr_data: write max_remaining_length, only while idle
// path: a byte taken from rx passes the input register, then the result register
//   (two registers; the parse step sits between them)
// throughput: one byte per cycle while parsed is not held
// stall: when parsed is held, the result register keeps its transaction and
//   the input register takes one more byte; rx then deasserts ready
// reset (rst, synchronous): parser back to waiting for a type byte, errors
//   cleared, both registers empty, limit back to 1048576
// errors: a length over the limit, or a fourth length byte that still has its
//   continuation bit set, is sticky; every later byte is classed ignored until reset
`include "mqtt_packet_stream_parser_assert.svh"

module mqtt_packet_stream_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [mpsp_pkg::LEN_W-1:0]   cfg_wr_data,
  mpsp_byte_if.sink                    rx,
  mpsp_result_if.source                parsed
);

  // configured length limit
  logic [mpsp_pkg::LEN_W-1:0] max_len;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // parser state
  mpsp_pkg::parse_state_t st;
  mpsp_pkg::parse_state_t st_next;

  // result register
  logic              out_valid;
  mpsp_pkg::result_t out_res;
  mpsp_pkg::result_t step_res;

  logic advance;

  // terms used by the checks
  logic err_set;
  logic halted;
  logic out_err;

  // input register moves on when the result register is free or being drained
  assign advance  = in_valid && (!out_valid || parsed.ready);
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= mpsp_pkg::MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  mpsp_step u_step (
    .st      (st),
    .rx_byte (in_byte),
    .max_len (max_len),
    .st_next (st_next),
    .res     (step_res)
  );

  // state only moves when a byte is handed to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase      <= mpsp_pkg::PH_TYPE;
      st.ctype      <= '0;
      st.qos        <= '0;
      st.accum      <= '0;
      st.count      <= '0;
      st.body_left  <= '0;
      st.topic_left <= '0;
      st.err        <= mpsp_pkg::ERR_NONE;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (parsed.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign parsed.valid        = out_valid;
  assign parsed.byte_class   = out_res.byte_class;
  assign parsed.data_byte    = out_res.data_byte;
  assign parsed.packet_type  = out_res.packet_type;
  assign parsed.qos_level    = out_res.qos_level;
  assign parsed.packet_end   = out_res.packet_end;
  assign parsed.error_status = out_res.error_status;

  // checks
  assign err_set = (st.err != mpsp_pkg::ERR_NONE);
  assign halted  = (st.phase == mpsp_pkg::PH_HALT);
  assign out_err = (out_res.error_status != mpsp_pkg::ERR_NONE);

  `MPSP_ASSERT_NEXT(a_err_sticky, err_set, st.err == $past(st.err), "error cleared")
  `MPSP_ASSERT_NOW(a_halt_err, 1'b1, halted == err_set, "halt phase and error disagree")
  `MPSP_ASSERT_NOW(a_err_no_end, out_valid && out_err, !out_res.packet_end, "end after error")
  `MPSP_ASSERT_NOW(a_len_count, st.phase == mpsp_pkg::PH_LEN, st.count <= 3'd3, "length too long")

endmodule
